// ----- rtl/dpnq_pkg.sv -----
// ----------------------------------------------------------------------------
// dpnq_pkg
// Shared types and codes for the deduplicating priority notice queue.
// ----------------------------------------------------------------------------
package dpnq_pkg;

    // Operation codes carried in the kind field
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Status codes reported with every result word
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_EVICTED   = 3'd3,
        ST_POPPED    = 3'd4,
        ST_POP_EMPTY = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    // Slot-store command: write new data, or copy one slot to another
    typedef struct packed {
        logic wr_en;
        logic copy;
    } store_ctl_t;

endpackage

// ----- rtl/dpnq_store.sv -----
// ----------------------------------------------------------------------------
// dpnq_store
// Register slot store: one read port, one write or slot-to-slot copy a cycle.
// ----------------------------------------------------------------------------
module dpnq_store
    import dpnq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4,
    parameter int CODE_BITS   = 4,
    localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
)
(
    input  logic                 clk,
    input  store_ctl_t           ctl,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [CODE_BITS-1:0] wr_data,
    output logic [CODE_BITS-1:0] rd_data,
    output logic [CODE_BITS-1:0] head
);

    logic [CODE_BITS-1:0] slot_reg [QUEUE_DEPTH];

    // Copy moves one slot toward head or tail; write places a new code
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            if (ctl.copy)
            begin
                slot_reg[wr_idx] <= slot_reg[rd_idx];
            end
            else
            begin
                slot_reg[wr_idx] <= wr_data;
            end
        end
    end

    assign rd_data = slot_reg[rd_idx];
    assign head    = slot_reg[0];

endmodule

// ----- rtl/dedup_priority_notice_queue.sv -----
// ----------------------------------------------------------------------------
// dedup_priority_notice_queue
// Bounded queue of nonzero notice codes with duplicate filtering, tail push,
// urgent head insert with tail eviction, pop and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation word: kind,
//   notice_code, urgent. Output channel (out_valid / out_stall) returns one
//   result word per operation: head code, valid flag, count and status.
//   A word moves at a clock edge with valid high and stall low.
//   One operation is worked at a time by a small sequencer around a single
//   slot store port and one code comparator. in_stall is high from accept
//   until the result is loaded into the output register.
//   A push scans one occupied slot a cycle for duplicates, then an urgent
//   push shifts one slot a cycle toward the tail before the code is placed.
//   The output register holds a result while out_stall is high; the next
//   operation is accepted and worked meanwhile and waits at its end.
//   Reset empties the queue (count zero) and drops any pending result;
//   slot contents are not cleared since only occupied slots are ever read.
// ----------------------------------------------------------------------------
module dedup_priority_notice_queue
    import dpnq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4,
    parameter int CODE_BITS   = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [3:0] notice_code,
    input  logic       urgent,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] visible_code,
    output logic       visible_valid,
    output logic [2:0] entry_count,
    output logic [2:0] status
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CODE_BITS > 4) ? CODE_BITS : 4;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    status_t              result_reg, result_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic                 urgent_reg, urgent_next;

    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           vis_code_reg, vis_code_next;
    logic                 vis_valid_reg, vis_valid_next;
    logic [2:0]           cnt_out_reg, cnt_out_next;
    status_t              status_reg, status_next;

    store_ctl_t           st_ctl;
    logic [IDX_W-1:0]     st_rd_idx;
    logic [IDX_W-1:0]     st_wr_idx;
    logic [CODE_BITS-1:0] st_rd_data;
    logic [CODE_BITS-1:0] st_head;

    logic                 in_take;
    logic                 out_free;
    logic [EXT_W-1:0]     code_wide;
    logic [CODE_BITS-1:0] code_in;
    logic [EXT_W-1:0]     head_wide;
    logic                 at_last;
    logic                 full;

    dpnq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CODE_BITS   (CODE_BITS)
    ) u_store (
        .clk     (clk),
        .ctl     (st_ctl),
        .rd_idx  (st_rd_idx),
        .wr_idx  (st_wr_idx),
        .wr_data (code_reg),
        .rd_data (st_rd_data),
        .head    (st_head)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Keep only the low CODE_BITS of the pushed code
    assign code_wide = EXT_W'(notice_code);
    assign code_in   = code_wide[CODE_BITS-1:0];
    assign head_wide = EXT_W'(st_head);

    // idx points at the last occupied slot
    assign at_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign full      = (count_reg == CNT_FULL);

    // Store port steering
    always_comb
    begin
        st_ctl    = '0;
        st_rd_idx = idx_reg;
        st_wr_idx = idx_reg;
        unique case (state_reg)
            S_SHIFT_UP:
            begin
                // move slot idx-1 one place toward the tail
                st_ctl.wr_en = 1'b1;
                st_ctl.copy  = 1'b1;
                st_rd_idx    = idx_reg - IDX_W'(1);
            end
            S_SHIFT_DN:
            begin
                // move slot idx one place toward the head
                st_ctl.wr_en = 1'b1;
                st_ctl.copy  = 1'b1;
                st_wr_idx    = idx_reg - IDX_W'(1);
            end
            S_PLACE:
            begin
                st_ctl.wr_en = 1'b1;
            end
            default:
            begin
                st_ctl = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        code_next      = code_reg;
        urgent_next    = urgent_reg;
        out_valid_next = out_valid_reg && out_stall;
        vis_code_next  = vis_code_reg;
        vis_valid_next = vis_valid_reg;
        cnt_out_next   = cnt_out_reg;
        status_next    = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    code_next   = code_in;
                    urgent_next = urgent;
                    state_next  = S_DONE;
                    unique case (kind)
                        KIND_PUSH:
                        begin
                            idx_next = '0;
                            if (code_in == '0)
                            begin
                                result_next = ST_IGNORED;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_DECIDE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        KIND_POP:
                        begin
                            idx_next = IDX_W'(1);
                            if (count_reg == '0)
                            begin
                                result_next = ST_POP_EMPTY;
                            end
                            else if (count_reg == CNT_W'(1))
                            begin
                                count_next  = '0;
                                result_next = ST_POPPED;
                            end
                            else
                            begin
                                state_next = S_SHIFT_DN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next  = '0;
                            result_next = ST_CLEARED;
                        end
                        default:
                        begin
                            result_next = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // compare one occupied slot a cycle
                if (st_rd_data == code_reg)
                begin
                    result_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else if (at_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DECIDE:
            begin
                result_next = full ? ST_EVICTED : ST_INSERTED;
                if (full && !urgent_reg)
                begin
                    result_next = ST_DROPPED;
                    state_next  = S_DONE;
                end
                else if (urgent_reg)
                begin
                    // the tail slot is overwritten when full
                    idx_next = full ? IDX_LAST : count_reg[IDX_W-1:0];
                    if (count_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_UP;
                    end
                end
                else
                begin
                    idx_next   = count_reg[IDX_W-1:0];
                    state_next = S_PLACE;
                end
            end
            S_SHIFT_UP:
            begin
                idx_next = idx_reg - IDX_W'(1);
                if (idx_reg == IDX_W'(1))
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_SHIFT_DN:
            begin
                if (at_last)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    result_next = ST_POPPED;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    vis_valid_next = (count_reg != '0);
                    vis_code_next  = (count_reg != '0) ? head_wide[3:0] : 4'd0;
                    cnt_out_next   = 3'(count_reg);
                    status_next    = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= ST_INSERTED;
            idx_reg       <= '0;
            code_reg      <= '0;
            urgent_reg    <= 1'b0;
            vis_code_reg  <= 4'd0;
            vis_valid_reg <= 1'b0;
            cnt_out_reg   <= 3'd0;
            status_reg    <= ST_INSERTED;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
            idx_reg       <= idx_next;
            code_reg      <= code_next;
            urgent_reg    <= urgent_next;
            vis_code_reg  <= vis_code_next;
            vis_valid_reg <= vis_valid_next;
            cnt_out_reg   <= cnt_out_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign visible_code  = vis_code_reg;
    assign visible_valid = vis_valid_reg;
    assign entry_count   = cnt_out_reg;
    assign status        = status_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free && result_reg == ST_DROPPED) |-> full)
        else $error("drop reported with free slot");

    a_pop_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free && result_reg == ST_POP_EMPTY)
        |-> (count_reg == '0))
        else $error("pop on empty with entries queued");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SHIFT_DN)
        |-> (CNT_W'(idx_reg) < count_reg))
        else $error("slot index past occupied range");
`endif

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deduplicating priority notice queue. A mirror of
// the slot contents predicts the head report for every accepted operation;
// reports are compared field by field in order. Directed corner cases come
// first, then bursty random traffic against a receiver that stalls on its own
// pattern and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb
    import dpnq_pkg::*;
();

    localparam int QUEUE_DEPTH  = 4;
    localparam int RANDOM_WORDS = 500;
    localparam int LONG_HOLD    = 80;
    // worst operation is an urgent push on a full queue
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

    typedef struct packed {
        logic [3:0] code;
        logic       present;
        logic [2:0] fill;
        logic [2:0] outcome;
    } head_report_t;

    // Mirror of the queue plus the list of head reports still owed by the block.
    class notice_scoreboard;
        logic [3:0]   mirror_slots [QUEUE_DEPTH];
        int unsigned  mirror_count;
        head_report_t pending_reports [$];
        int unsigned  failures;

        function new();
            foreach (mirror_slots[i])
                mirror_slots[i] = '0;
            mirror_count = 0;
            failures     = 0;
        endfunction

        function bit holds_code(logic [3:0] code);
            for (int i = 0; i < mirror_count; i++)
            begin
                if (mirror_slots[i] == code)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [2:0] push_code(logic [3:0] code, logic at_head);
            int unsigned used;
            logic [2:0]  outcome;
            outcome = ST_INSERTED;
            // drop the none code and anything already queued
            if (code == '0 || holds_code(code))
                return ST_IGNORED;
            used = mirror_count;
            if (used == QUEUE_DEPTH)
            begin
                if (!at_head)
                    return ST_DROPPED;
                // make room at the tail for the urgent word
                used = QUEUE_DEPTH - 1;
                mirror_slots[used] = '0;
                outcome = ST_EVICTED;
            end
            if (at_head)
            begin
                for (int i = used; i > 0; i--)
                    mirror_slots[i] = mirror_slots[i - 1];
                mirror_slots[0] = code;
            end
            else
                mirror_slots[used] = code;
            mirror_count = used + 1;
            return outcome;
        endfunction

        function logic [2:0] pop_head();
            if (mirror_count == 0)
                return ST_POP_EMPTY;
            for (int i = 1; i < mirror_count; i++)
                mirror_slots[i - 1] = mirror_slots[i];
            mirror_count--;
            mirror_slots[mirror_count] = '0;
            return ST_POPPED;
        endfunction

        function void note_operation(logic [1:0] kind, logic [3:0] code, logic at_head);
            head_report_t report;
            case (kind)
                KIND_PUSH:  report.outcome = push_code(code, at_head);
                KIND_POP:   report.outcome = pop_head();
                KIND_CLEAR:
                begin
                    foreach (mirror_slots[i])
                        mirror_slots[i] = '0;
                    mirror_count   = 0;
                    report.outcome = ST_CLEARED;
                end
                default:    report.outcome = ST_IGNORED;
            endcase
            report.present = (mirror_count != 0);
            report.code    = report.present ? mirror_slots[0] : 4'd0;
            report.fill    = mirror_count[2:0];
            pending_reports.push_back(report);
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_report(head_report_t got);
            head_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result word: code %0d valid %0d count %0d status %0d",
                       got.code, got.present, got.fill, got.outcome);
                failures++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("visible_code", want.code, got.code);
            compare_field("visible_valid", {3'b0, want.present}, {3'b0, got.present});
            compare_field("entry_count", {1'b0, want.fill}, {1'b0, got.fill});
            compare_field("status", {1'b0, want.outcome}, {1'b0, got.outcome});
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] kind;
    logic [3:0] notice_code;
    logic       urgent;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] visible_code;
    logic       visible_valid;
    logic [2:0] entry_count;
    logic [2:0] status;

    // raised by the sender to ask the receiver for one long hold-off
    bit hold_request = 1'b0;

    notice_scoreboard sb = new();

    dedup_priority_notice_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CODE_BITS   (4)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .notice_code   (notice_code),
        .urgent        (urgent),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .visible_code  (visible_code),
        .visible_valid (visible_valid),
        .entry_count   (entry_count),
        .status        (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watch both channels at the edge; values read here are the pre-edge ones.
    // Check before noting: a word accepted now cannot have its result out yet.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_report('{visible_code, visible_valid, entry_count, status});
        if (rst_n && in_valid && !in_stall)
            sb.note_operation(kind, notice_code, urgent);
    end

    // Offer one operation word and hold it until the block takes it.
    // Call at a rising edge; returns at the edge where the word moved.
    task automatic send_word(input logic [1:0] k, input logic [3:0] c, input logic u);
        in_valid    <= 1'b1;
        kind        <= k;
        notice_code <= c;
        urgent      <= u;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid for a gap between bursts.
    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Mostly pushes, so the queue runs full and drops and evictions are common;
    // codes lean on a small pool to provoke duplicates.
    function automatic void pick_word(output logic [1:0] k, output logic [3:0] c,
                                      output logic u);
        int roll;
        roll = $urandom_range(0, 99);
        c    = 4'($urandom_range(0, 15));
        u    = 1'($urandom_range(0, 1));
        if (roll < 60)
        begin
            k = KIND_PUSH;
            u = (roll >= 38);
            if ($urandom_range(0, 9) == 0)
                c = 4'd0;
            else if ($urandom_range(0, 1) == 1)
                c = 4'($urandom_range(1, 6));
            else
                c = 4'($urandom_range(1, 15));
        end
        else if (roll < 88)
            k = KIND_POP;
        else if (roll < 95)
            k = KIND_CLEAR;
        else
            k = KIND_UNUSED;
    endfunction

    // Stimulus: reset, directed corner cases, then bursty random traffic.
    initial
    begin : stimulus
        int         sent;
        int         burst;
        logic [1:0] k;
        logic [3:0] c;
        logic       u;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_PUSH;
        notice_code = 4'd0;
        urgent      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pop on an empty queue, push of none, fill to the brim
        send_word(KIND_POP, 4'd0, 1'b0);
        send_word(KIND_PUSH, 4'd0, 1'b0);
        send_word(KIND_PUSH, 4'd0, 1'b1);
        send_word(KIND_PUSH, 4'd1, 1'b0);
        send_word(KIND_PUSH, 4'd2, 1'b0);
        send_word(KIND_PUSH, 4'd2, 1'b0);
        send_word(KIND_PUSH, 4'd15, 1'b0);
        send_word(KIND_PUSH, 4'd8, 1'b0);
        // full: normal push drops, urgent push evicts the tail, urgent duplicate ignored
        send_word(KIND_PUSH, 4'd7, 1'b0);
        send_word(KIND_PUSH, 4'd9, 1'b1);
        send_word(KIND_PUSH, 4'd15, 1'b1);
        send_word(KIND_PUSH, 4'd8, 1'b0);
        // unused kind and pop with live push fields
        send_word(KIND_UNUSED, 4'd5, 1'b1);
        send_word(KIND_POP, 4'd15, 1'b1);
        send_word(KIND_PUSH, 4'd6, 1'b1);
        send_word(KIND_POP, 4'd10, 1'b0);
        send_word(KIND_POP, 4'd0, 1'b1);
        send_word(KIND_POP, 4'd3, 1'b0);
        send_word(KIND_POP, 4'd0, 1'b0);
        send_word(KIND_POP, 4'd0, 1'b0);
        // clear with fields set, then clear on empty
        send_word(KIND_PUSH, 4'd4, 1'b1);
        send_word(KIND_PUSH, 4'd11, 1'b0);
        send_word(KIND_CLEAR, 4'd15, 1'b1);
        send_word(KIND_CLEAR, 4'd0, 1'b0);
        send_word(KIND_PUSH, 4'd12, 1'b0);

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < RANDOM_WORDS; b++)
            begin
                pick_word(k, c, u);
                send_word(k, c, u);
                sent++;
                if (sent == RANDOM_WORDS / 2)
                begin
                    // keep offering words back to back while the receiver holds off
                    hold_request = 1'b1;
                    repeat (24)
                    begin
                        pick_word(k, c, u);
                        send_word(k, c, u);
                    end
                end
            end
            // some bursts run straight into the next one
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
        in_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: segments of free flow, coin-flip stalls, a fixed every-third
    // pattern and heavy stalling, plus one long hold-off on request.
    initial
    begin : receiver
        int seg_mode;
        int seg_len;
        bit stall_now;

        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            seg_mode = $urandom_range(0, 3);
            seg_len  = $urandom_range(5, 40);
            for (int i = 0; i < seg_len; i++)
            begin
                if (hold_request)
                begin
                    // hold off long enough for the block to stall its input
                    hold_request = 1'b0;
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (seg_mode)
                    0:       stall_now = 1'b0;
                    1:       stall_now = 1'($urandom_range(0, 1));
                    2:       stall_now = (i % 3 == 0);
                    default: stall_now = ($urandom_range(0, 9) < 8);
                endcase
                out_stall <= stall_now;
                @(posedge clk);
            end
        end
    end

    // Guard against a hung handshake.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
